// ===== rtl/adp_pkg.sv =====
// Shared types and constants for the ARM data-processing execute block.
package adp_pkg;

   // Register file geometry: r0-r14 live in storage, r15 is the supplied pc.
   localparam int NumRegs = 15;
   localparam logic [3:0] PcIdx = 4'd15;

   // Data-processing opcodes.
   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_ADC = 4'd5,
      OP_SBC = 4'd6,
      OP_RSC = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_CMN = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_BIC = 4'd14,
      OP_MVN = 4'd15
   } alu_op_type;

   // Condition codes; NV is treated as never.
   typedef enum logic [3:0] {
      CC_EQ = 4'd0,
      CC_NE = 4'd1,
      CC_CS = 4'd2,
      CC_CC = 4'd3,
      CC_MI = 4'd4,
      CC_PL = 4'd5,
      CC_VS = 4'd6,
      CC_VC = 4'd7,
      CC_HI = 4'd8,
      CC_LS = 4'd9,
      CC_GE = 4'd10,
      CC_LT = 4'd11,
      CC_GT = 4'd12,
      CC_LE = 4'd13,
      CC_AL = 4'd14,
      CC_NV = 4'd15
   } cond_type;

   // Shift kinds for the register operand.
   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_kind_type;

   // One decoded request as it travels to the execute stage.
   typedef struct packed {
      alu_op_type     cmd;
      cond_type       condition;
      logic           set_flags;
      logic           imm_form;
      logic [3:0]     first_reg;
      logic [3:0]     dest_sel;
      logic [3:0]     second_reg;
      shift_kind_type shift_kind;
      logic [4:0]     shift_amount;
      logic [3:0]     rotate_half;
      logic [7:0]     imm_byte;
      logic [31:0]    pc_read_value;
   } req_type;

   // Barrel shifter output: second operand and shifter carry.
   typedef struct packed {
      logic [31:0] operand;
      logic        carry;
   } shift_out_type;

   // Execute result and the side effects it requests.
   typedef struct packed {
      logic        executed;
      logic        reg_write;
      logic        pc_write;
      logic [31:0] result;
      logic [3:0]  nzcv;
   } alu_out_type;

endpackage

// ===== rtl/arm_data_processing_alu.sv =====
// Top level of the ARM data-processing execute block.
//
// A request carries one data-processing instruction on req_* and is taken
// when req_valid and req_ready are both high. The result leaves on rsp_*
// and is taken when rsp_valid and rsp_ready are both high.
// Flow: at the accepting edge the register file r0-r14 is read (synchronous
// memory, two read ports); in the next cycle the shifter, ALU and flag logic
// evaluate the instruction and, once the output register is free or draining,
// write back to the register file and load the output register, which sets
// rsp_valid. Throughput is one request per cycle while the receiver does not
// stall; a result written at the same edge as the next request's read is
// forwarded around the memory.
// If the receiver stalls, one result waits in the output register and one
// request waits in the execute stage with its operands re-read each cycle;
// req_ready drops only when both are full.
// Reset clears the flags to zero and marks every register as zero; the
// block can take a request in the first cycle after reset.
module arm_data_processing_alu import adp_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_cmd,
   input  logic [3:0]  req_condition,
   input  logic        req_set_flags,
   input  logic        req_imm_form,
   input  logic [3:0]  req_first_reg,
   input  logic [3:0]  req_dest_sel,
   input  logic [3:0]  req_second_reg,
   input  logic [1:0]  req_shift_kind,
   input  logic [4:0]  req_shift_amount,
   input  logic [3:0]  req_rotate_half,
   input  logic [7:0]  req_imm_byte,
   input  logic [31:0] req_pc_read_value,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_executed,
   output logic        rsp_reg_write,
   output logic [3:0]  rsp_dest_reg,
   output logic [31:0] rsp_result_value,
   output logic [3:0]  rsp_flags_nzcv,
   output logic        rsp_pc_write
);

   req_type       req_in;
   req_type       ex_req_ff;
   logic          ex_valid_ff, ex_valid_in;
   logic          req_fire, ex_fire;
   logic [3:0]    rd_addr_a, rd_addr_b;
   logic [31:0]   rd_data_a, rd_data_b;
   logic [31:0]   op_a, op_m;
   shift_out_type shift_out;
   alu_out_type   alu_out;
   logic [3:0]    flags_ff;
   logic          out_valid_ff, out_valid_in;
   alu_out_type   out_ff;
   logic [3:0]    out_dest_ff;

   // Pack the request fields.
   always_comb begin
      req_in.cmd           = alu_op_type'(req_cmd);
      req_in.condition     = cond_type'(req_condition);
      req_in.set_flags     = req_set_flags;
      req_in.imm_form      = req_imm_form;
      req_in.first_reg     = req_first_reg;
      req_in.dest_sel      = req_dest_sel;
      req_in.second_reg    = req_second_reg;
      req_in.shift_kind    = shift_kind_type'(req_shift_kind);
      req_in.shift_amount  = req_shift_amount;
      req_in.rotate_half   = req_rotate_half;
      req_in.imm_byte      = req_imm_byte;
      req_in.pc_read_value = req_pc_read_value;
   end

   // Handshake: execute fires when the output register is free or draining.
   always_comb begin
      ex_fire      = ex_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready    = !ex_valid_ff || ex_fire;
      req_fire     = req_valid && req_ready;
      ex_valid_in  = req_fire || (ex_valid_ff && !ex_fire);
      out_valid_in = ex_fire || (out_valid_ff && !rsp_ready);
   end

   // Read a new request's operands, or re-read for a stalled one.
   always_comb begin
      rd_addr_a = req_fire ? req_first_reg  : ex_req_ff.first_reg;
      rd_addr_b = req_fire ? req_second_reg : ex_req_ff.second_reg;
   end

   adp_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (ex_fire && alu_out.reg_write),
      .wr_addr   (ex_req_ff.dest_sel),
      .wr_data   (alu_out.result)
   );

   // Register r15 reads return the pc value supplied with the request.
   always_comb begin
      op_a = (ex_req_ff.first_reg  == PcIdx) ? ex_req_ff.pc_read_value : rd_data_a;
      op_m = (ex_req_ff.second_reg == PcIdx) ? ex_req_ff.pc_read_value : rd_data_b;
   end

   adp_shifter u_shifter (
      .imm_form     (ex_req_ff.imm_form),
      .shift_kind   (ex_req_ff.shift_kind),
      .shift_amount (ex_req_ff.shift_amount),
      .rotate_half  (ex_req_ff.rotate_half),
      .imm_byte     (ex_req_ff.imm_byte),
      .reg_value    (op_m),
      .carry_in     (flags_ff[1]),
      .shift_out    (shift_out)
   );

   adp_alu u_alu (
      .req       (ex_req_ff),
      .op_a      (op_a),
      .shift_out (shift_out),
      .flags     (flags_ff),
      .alu_out   (alu_out)
   );

   // Execute stage and flag register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
         flags_ff    <= 4'd0;
      end else begin
         ex_valid_ff <= ex_valid_in;
         if (ex_fire) begin
            flags_ff <= alu_out.nzcv;
         end
      end
      if (req_fire) begin
         ex_req_ff <= req_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (ex_fire) begin
         out_ff      <= alu_out;
         out_dest_ff <= ex_req_ff.dest_sel;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_executed     = out_ff.executed;
   assign rsp_reg_write    = out_ff.reg_write;
   assign rsp_dest_reg     = out_dest_ff;
   assign rsp_result_value = out_ff.result;
   assign rsp_flags_nzcv   = out_ff.nzcv;
   assign rsp_pc_write     = out_ff.pc_write;

endmodule

// ===== rtl/adp_regfile.sv =====
// Register file r0-r14: synchronous memory with two read ports and write forwarding.
module adp_regfile import adp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [3:0]  rd_addr_a,
   input  logic [3:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [31:0] wr_data
);

   logic [31:0]        mem [NumRegs];
   logic [NumRegs-1:0] written_ff;

   logic [31:0] q_a_ff, q_b_ff;
   logic        vld_a_ff, vld_b_ff;
   logic [3:0]  addr_a_ff, addr_b_ff;

   logic        fwd_ff;
   logic [3:0]  fwd_addr_ff;
   logic [31:0] fwd_data_ff;

   // Storage write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Per-entry written bits; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered reads; the pc index has no storage behind it.
   always_ff @(posedge clock) begin
      addr_a_ff <= rd_addr_a;
      addr_b_ff <= rd_addr_b;
      vld_a_ff  <= 1'b0;
      vld_b_ff  <= 1'b0;
      if (rd_addr_a != PcIdx) begin
         q_a_ff   <= mem[rd_addr_a];
         vld_a_ff <= written_ff[rd_addr_a];
      end
      if (rd_addr_b != PcIdx) begin
         q_b_ff   <= mem[rd_addr_b];
         vld_b_ff <= written_ff[rd_addr_b];
      end
   end

   // Remember a write made at the same edge as a read, which the read missed.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= wr_en;
      end
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
   end

   // Read data with forwarding of that write.
   always_comb begin
      if (fwd_ff && (fwd_addr_ff == addr_a_ff)) begin
         rd_data_a = fwd_data_ff;
      end else begin
         rd_data_a = vld_a_ff ? q_a_ff : 32'd0;
      end
      if (fwd_ff && (fwd_addr_ff == addr_b_ff)) begin
         rd_data_b = fwd_data_ff;
      end else begin
         rd_data_b = vld_b_ff ? q_b_ff : 32'd0;
      end
   end

endmodule

// ===== rtl/adp_shifter.sv =====
// Barrel shifter producing the second operand and the shifter carry.
module adp_shifter import adp_pkg::*; (
   input  logic           imm_form,
   input  shift_kind_type shift_kind,
   input  logic [4:0]     shift_amount,
   input  logic [3:0]     rotate_half,
   input  logic [7:0]     imm_byte,
   input  logic [31:0]    reg_value,
   input  logic           carry_in,
   output shift_out_type  shift_out
);

   logic [4:0]  rot_amt;
   logic [63:0] imm_wide;
   logic [63:0] reg_wide;
   logic [31:0] imm_rot;
   logic [31:0] reg_rot;
   logic [32:0] lsl_wide;
   logic [32:0] lsr_wide;
   logic [32:0] asr_wide;

   always_comb begin
      // Immediate rotate right by twice the rotate field.
      rot_amt  = {rotate_half, 1'b0};
      imm_wide = {24'd0, imm_byte, 24'd0, imm_byte} >> rot_amt;
      imm_rot  = imm_wide[31:0];

      // Register shifts carry the last bit shifted out in the extra bit.
      lsl_wide = {1'b0, reg_value} << shift_amount;
      lsr_wide = {reg_value, 1'b0} >> shift_amount;
      asr_wide = 33'($signed({reg_value, 1'b0}) >>> shift_amount);
      reg_wide = {reg_value, reg_value} >> shift_amount;
      reg_rot  = reg_wide[31:0];

      shift_out.operand = reg_value;
      shift_out.carry   = carry_in;
      if (imm_form) begin
         shift_out.operand = imm_rot;
         shift_out.carry   = (rotate_half == 4'd0) ? carry_in : imm_rot[31];
      end else begin
         case (shift_kind)
            SH_LSL: begin
               if (shift_amount != 5'd0) begin
                  shift_out.operand = lsl_wide[31:0];
                  shift_out.carry   = lsl_wide[32];
               end
            end
            SH_LSR: begin
               // A zero amount means a shift by 32.
               if (shift_amount == 5'd0) begin
                  shift_out.operand = 32'd0;
                  shift_out.carry   = reg_value[31];
               end else begin
                  shift_out.operand = lsr_wide[32:1];
                  shift_out.carry   = lsr_wide[0];
               end
            end
            SH_ASR: begin
               if (shift_amount == 5'd0) begin
                  shift_out.operand = {32{reg_value[31]}};
                  shift_out.carry   = reg_value[31];
               end else begin
                  shift_out.operand = asr_wide[32:1];
                  shift_out.carry   = asr_wide[0];
               end
            end
            SH_ROR: begin
               // A zero amount is a rotate right through carry by one.
               if (shift_amount == 5'd0) begin
                  shift_out.operand = {carry_in, reg_value[31:1]};
                  shift_out.carry   = reg_value[0];
               end else begin
                  shift_out.operand = reg_rot;
                  shift_out.carry   = reg_rot[31];
               end
            end
            default: begin
               shift_out.operand = reg_value;
               shift_out.carry   = carry_in;
            end
         endcase
      end
   end

endmodule

// ===== rtl/adp_alu.sv =====
// Condition check, ALU operation and flag update for one instruction.
module adp_alu import adp_pkg::*; (
   input  req_type       req,
   input  logic [31:0]   op_a,
   input  shift_out_type shift_out,
   input  logic [3:0]    flags,
   output alu_out_type   alu_out
);

   logic        fn, fz, fc, fv;
   logic        pass;
   logic        is_cmp;
   logic        is_arith;
   logic [31:0] op_b;
   logic [31:0] add_x, add_y;
   logic        add_cin;
   logic [32:0] sum;
   logic [31:0] logic_res;
   logic [31:0] res;
   logic        c_out, v_out;

   always_comb begin
      fn = flags[3];
      fz = flags[2];
      fc = flags[1];
      fv = flags[0];
      op_b = shift_out.operand;

      // Condition evaluation against the kept flags.
      case (req.condition)
         CC_EQ:   pass = fz;
         CC_NE:   pass = !fz;
         CC_CS:   pass = fc;
         CC_CC:   pass = !fc;
         CC_MI:   pass = fn;
         CC_PL:   pass = !fn;
         CC_VS:   pass = fv;
         CC_VC:   pass = !fv;
         CC_HI:   pass = fc && !fz;
         CC_LS:   pass = !fc || fz;
         CC_GE:   pass = (fn == fv);
         CC_LT:   pass = (fn != fv);
         CC_GT:   pass = !fz && (fn == fv);
         CC_LE:   pass = fz || (fn != fv);
         CC_AL:   pass = 1'b1;
         default: pass = 1'b0;
      endcase

      // Operand selection for the single adder.
      is_arith = 1'b1;
      add_x    = op_a;
      add_y    = op_b;
      add_cin  = 1'b0;
      case (req.cmd)
         OP_SUB, OP_CMP: begin
            add_y   = ~op_b;
            add_cin = 1'b1;
         end
         OP_RSB: begin
            add_x   = op_b;
            add_y   = ~op_a;
            add_cin = 1'b1;
         end
         OP_ADD, OP_CMN: begin
            add_cin = 1'b0;
         end
         OP_ADC: begin
            add_cin = fc;
         end
         OP_SBC: begin
            add_y   = ~op_b;
            add_cin = fc;
         end
         OP_RSC: begin
            add_x   = op_b;
            add_y   = ~op_a;
            add_cin = fc;
         end
         default: begin
            is_arith = 1'b0;
         end
      endcase
      sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};

      // Logical operations.
      case (req.cmd)
         OP_AND, OP_TST: logic_res = op_a & op_b;
         OP_EOR, OP_TEQ: logic_res = op_a ^ op_b;
         OP_ORR:         logic_res = op_a | op_b;
         OP_MOV:         logic_res = op_b;
         OP_BIC:         logic_res = op_a & ~op_b;
         OP_MVN:         logic_res = ~op_b;
         default:        logic_res = 32'd0;
      endcase

      // Arithmetic takes carry and overflow from the adder; logical ops keep V.
      if (is_arith) begin
         res   = sum[31:0];
         c_out = sum[32];
         v_out = (~(add_x[31] ^ add_y[31])) & (add_x[31] ^ sum[31]);
      end else begin
         res   = logic_res;
         c_out = shift_out.carry;
         v_out = fv;
      end

      is_cmp = (req.cmd == OP_TST) || (req.cmd == OP_TEQ) ||
               (req.cmd == OP_CMP) || (req.cmd == OP_CMN);

      // A failed condition leaves everything as it was.
      alu_out.executed  = pass;
      alu_out.reg_write = pass && !is_cmp && (req.dest_sel != PcIdx);
      alu_out.pc_write  = pass && !is_cmp && (req.dest_sel == PcIdx);
      alu_out.result    = pass ? res : 32'd0;
      if (pass && (req.set_flags || is_cmp)) begin
         alu_out.nzcv = {res[31], (res == 32'd0), c_out, v_out};
      end else begin
         alu_out.nzcv = flags;
      end
   end

endmodule
